>>> src/ilirs_pkg.sv
// ----------------------------------------------------------------------------
// ilirs_pkg
// Shared sizes, operation and status codes for the ordered list block.
// ----------------------------------------------------------------------------
`default_nettype none

package ilirs_pkg;

   localparam int DEPTH      = 16;
   localparam int ELEM_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int POS_W      = 5;
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      KIND_INSERT = 3'd0,
      KIND_REMOVE = 3'd1,
      KIND_READ   = 3'd2,
      KIND_SWAP   = 3'd3,
      KIND_SORT   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_UNDER = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CO_HOLD   = 3'd0,
      CO_INSERT = 3'd1,
      CO_REMOVE = 3'd2,
      CO_SWAP   = 3'd3,
      CO_SORT   = 3'd4
   } cell_op_type;

   // Broadcast control seen by every cell of the chain
   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] pos_b;
      logic [CNT_W-1:0] count;
      logic             parity;
      logic             sort_signed;
   } ctrl_type;

   // Flip the sign bit so a signed compare becomes an unsigned one
   function automatic logic [ELEM_WIDTH-1:0] sort_key(input logic [ELEM_WIDTH-1:0] data,
                                                      input logic sgn);
      sort_key = data ^ {sgn, {(ELEM_WIDTH-1){1'b0}}};
   endfunction

endpackage

`default_nettype wire

>>> src/ilirs_cell.sv
// ----------------------------------------------------------------------------
// ilirs_cell
// One list slot: holds an element, shifts with its neighbors, compare-swaps.
// ----------------------------------------------------------------------------
`default_nettype none

module ilirs_cell
   import ilirs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [IDX_W-1:0]      index,
   input  wire ctrl_type              ctrl,
   input  wire logic [ELEM_WIDTH-1:0] left_data,
   input  wire logic [ELEM_WIDTH-1:0] right_data,
   input  wire logic [ELEM_WIDTH-1:0] load_a,
   input  wire logic [ELEM_WIDTH-1:0] load_b,
   output logic      [ELEM_WIDTH-1:0] data
);

   logic [ELEM_WIDTH-1:0] data_ff;
   logic [ELEM_WIDTH-1:0] data_in;
   logic [ELEM_WIDTH-1:0] key_self;
   logic [ELEM_WIDTH-1:0] key_left;
   logic [ELEM_WIDTH-1:0] key_right;
   logic                  is_left;

   assign key_self  = sort_key(data_ff, ctrl.sort_signed);
   assign key_left  = sort_key(left_data, ctrl.sort_signed);
   assign key_right = sort_key(right_data, ctrl.sort_signed);
   // pair (i, i+1) compared when i has the phase parity
   assign is_left   = (index[0] == ctrl.parity);

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CO_INSERT: begin
            if (index == ctrl.pos) begin
               data_in = load_a;
            end else if (index > ctrl.pos) begin
               data_in = left_data;
            end
         end
         CO_REMOVE: begin
            if (index >= ctrl.pos && index != IDX_W'(DEPTH - 1)) begin
               data_in = right_data;
            end
         end
         CO_SWAP: begin
            if (index == ctrl.pos) begin
               data_in = load_a;
            end else if (index == ctrl.pos_b) begin
               data_in = load_b;
            end
         end
         CO_SORT: begin
            if (is_left) begin
               if ((CNT_W'(index) + CNT_W'(1) < ctrl.count) && (key_self > key_right)) begin
                  data_in = right_data;
               end
            end else begin
               if ((index != '0) && (CNT_W'(index) < ctrl.count) && (key_left > key_self)) begin
                  data_in = left_data;
               end
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

>>> src/ilirs_chain.sv
// ----------------------------------------------------------------------------
// ilirs_chain
// Row of list cells wired to their neighbors, plus the single read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ilirs_chain
   import ilirs_pkg::*;
(
   input  wire logic                  clock,
   input  wire ctrl_type              ctrl,
   input  wire logic [ELEM_WIDTH-1:0] load_a,
   input  wire logic [ELEM_WIDTH-1:0] load_b,
   input  wire logic [IDX_W-1:0]      rd_addr,
   output logic      [ELEM_WIDTH-1:0] rd_data
);

   logic [ELEM_WIDTH-1:0] elem [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_data;
      logic [ELEM_WIDTH-1:0] right_data;

      if (g == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = elem[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = elem[g+1];
      end

      ilirs_cell u_cell (
         .clock      (clock),
         .index      (IDX_W'(g)),
         .ctrl       (ctrl),
         .left_data  (left_data),
         .right_data (right_data),
         .load_a     (load_a),
         .load_b     (load_b),
         .data       (elem[g])
      );
   end

   assign rd_data = elem[rd_addr];

endmodule

`default_nettype wire

>>> src/indexed_list_insert_remove_sort_top.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_sort_top
// Bounded ordered list held in a chain of cells: insert, remove, read, swap,
// and ascending sort by odd-even transposition.
// ----------------------------------------------------------------------------
// Responses: insert, remove, read, unknown kinds and equal or out-of-range swaps
//   answer in the cycle after accept with busy low: one transaction per cycle.
// Swap passes through the S_SWAP state with busy high (one read port: the second
//   entry is read in the write cycle). Sort runs DEPTH transposition phases, one per cycle.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
// Reset (synchronous): list empty, sort_signed = 0; cell contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove_sort_top
   import ilirs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_kind,
   input  wire logic [4:0]  req_position,
   input  wire logic [4:0]  req_position_b,
   input  wire logic [31:0] req_value,
   // response channel
   output logic             rsp_valid,
   output logic [31:0]      rsp_read_value,
   output logic [4:0]       rsp_length,
   output logic [1:0]       rsp_status,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   // One-hot controller states
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SWAP = 3'b010,
      S_SORT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      phase_ff, phase_in;
   logic [IDX_W-1:0]      pos_a_ff, pos_a_in;
   logic [IDX_W-1:0]      pos_b_ff, pos_b_in;
   logic [ELEM_WIDTH-1:0] tmp_ff, tmp_in;
   logic                  sort_signed_ff;

   logic                  rsp_valid_ff;
   logic [31:0]           rsp_read_value_ff;
   logic [4:0]            rsp_length_ff;
   status_type            rsp_status_ff;

   logic                  rsp_load;
   logic [31:0]           rsp_read_in;
   status_type            rsp_status_in;

   ctrl_type              ctrl;
   logic [ELEM_WIDTH-1:0] load_a;
   logic [ELEM_WIDTH-1:0] load_b;
   logic [IDX_W-1:0]      rd_addr;
   logic [ELEM_WIDTH-1:0] rd_data;

   logic                  accept;
   logic                  pa_ok;
   logic                  pb_ok;
   logic [CMP_W-1:0]      pa_w;
   logic [CMP_W-1:0]      pb_w;
   logic [CMP_W-1:0]      count_w;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && (state_ff == S_IDLE);

   // positions compared against the count at a common width
   assign pa_w    = CMP_W'(req_position);
   assign pb_w    = CMP_W'(req_position_b);
   assign count_w = CMP_W'(count_ff);
   assign pa_ok   = (pa_w < count_w);
   assign pb_ok   = (pb_w < count_w);

   // Single read port: request position when idle, second swap index after
   assign rd_addr = (state_ff == S_SWAP) ? pos_b_ff : IDX_W'(req_position);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      phase_in         = phase_ff;
      pos_a_in         = pos_a_ff;
      pos_b_in         = pos_b_ff;
      tmp_in           = tmp_ff;
      rsp_load         = 1'b0;
      rsp_read_in      = '0;
      rsp_status_in    = ST_OK;
      ctrl.op          = CO_HOLD;
      ctrl.pos         = IDX_W'(req_position);
      ctrl.pos_b       = IDX_W'(req_position_b);
      ctrl.count       = count_ff;
      ctrl.parity      = phase_ff[0];
      ctrl.sort_signed = sort_signed_ff;
      load_a           = ELEM_WIDTH'(req_value);
      load_b           = tmp_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_INSERT: begin
                     rsp_load = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.op  = CO_INSERT;
                        // past the end means append
                        ctrl.pos = (pa_w > count_w) ? IDX_W'(count_ff)
                                                    : IDX_W'(req_position);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_REMOVE: begin
                     rsp_load = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = ST_UNDER;
                     end else begin
                        ctrl.op  = CO_REMOVE;
                        // past the end means the last entry
                        ctrl.pos = pa_ok ? IDX_W'(req_position)
                                         : IDX_W'(count_ff - CNT_W'(1));
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  KIND_READ: begin
                     rsp_load = 1'b1;
                     if (pa_ok) begin
                        rsp_read_in = 32'(rd_data);
                     end else begin
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  KIND_SWAP: begin
                     if (req_position == req_position_b) begin
                        rsp_load = 1'b1;
                     end else if (!(pa_ok && pb_ok)) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        // hold the first entry, write both in the next cycle
                        tmp_in   = rd_data;
                        pos_a_in = IDX_W'(req_position);
                        pos_b_in = IDX_W'(req_position_b);
                        state_in = S_SWAP;
                     end
                  end
                  KIND_SORT: begin
                     phase_in = '0;
                     state_in = S_SORT;
                  end
                  default: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_SWAP: begin
            ctrl.op    = CO_SWAP;
            ctrl.pos   = pos_a_ff;
            ctrl.pos_b = pos_b_ff;
            load_a     = rd_data;
            load_b     = tmp_ff;
            rsp_load   = 1'b1;
            state_in   = S_IDLE;
         end
         S_SORT: begin
            // DEPTH alternating phases sort any fill level
            ctrl.op  = CO_SORT;
            phase_in = phase_ff + IDX_W'(1);
            if (phase_ff == IDX_W'(DEPTH - 1)) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   ilirs_chain u_chain (
      .clock   (clock),
      .ctrl    (ctrl),
      .load_a  (load_a),
      .load_b  (load_b),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         phase_ff       <= '0;
         sort_signed_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_load;
         if (csr_wr_en) begin
            sort_signed_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_a_ff <= pos_a_in;
      pos_b_ff <= pos_b_in;
      tmp_ff   <= tmp_in;
      if (rsp_load) begin
         rsp_read_value_ff <= rsp_read_in;
         rsp_length_ff     <= 5'(count_in);
         rsp_status_ff     <= rsp_status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

>>> src/ilirs_checker.sv
// ----------------------------------------------------------------------------
// ilirs_checker
// Port-level checks of the ordered list block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ilirs_checker
   import ilirs_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [2:0]  req_kind,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_read_value,
   input wire logic [4:0]  rsp_length,
   input wire logic [1:0]  rsp_status
);

   logic take;
   assign take = start && !busy;

   // single-cycle operations answer in the next cycle
   a_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      take && (req_kind == KIND_INSERT || req_kind == KIND_REMOVE ||
               req_kind == KIND_READ) |=> rsp_valid)
      else $error("no response one cycle after a fast transaction");

   a_sort_busy: assert property (@(posedge clock) disable iff (reset)
      take && (req_kind == KIND_SORT) |=> busy)
      else $error("sort did not hold off new transactions");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length <= 5'(DEPTH)))
      else $error("reported length beyond capacity");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (rsp_length == 5'(DEPTH)))
      else $error("full status while list not full");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_read_value == '0))
      else $error("read value nonzero on failed transaction");

endmodule

bind indexed_list_insert_remove_sort_top ilirs_checker u_ilirs_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_read_value (rsp_read_value),
   .rsp_length     (rsp_length),
   .rsp_status     (rsp_status)
);

`default_nettype wire
